/* sv/pklpc_pkg.sv */
// ----------------------------------------------------------------------------
// pklpc_pkg
// Shared types, constants and the wrap-aware interval test for the power key
// long-press controller.
// ----------------------------------------------------------------------------
package pklpc_pkg;

	// timer wrap value, kept as the wrap formula in interval_exceeds uses it
	localparam logic [31:0] TIME_WRAP = 32'hFFFF_FFFF;

	// register reset values
	localparam logic [31:0] RELEASE_TICKS_RST    = 32'd5000;
	localparam logic [31:0] LONG_PRESS_TICKS_RST = 32'd50000;

	// configuration register indices
	typedef enum logic [0:0] {
		REG_RELEASE_TICKS    = 1'b0,
		REG_LONG_PRESS_TICKS = 1'b1
	} reg_index_t;

	// one polled input item
	typedef struct packed {
		logic        key_level;
		logic        rail_level;
		logic [31:0] now_time;
	} item_t;

	// one result item
	typedef struct packed {
		logic power_on_req;
		logic shutdown_req;
		logic force_off;
	} result_t;

	// interval from b to e longer than t, with the timer wrap taken into account
	function automatic logic interval_exceeds(logic [31:0] b, logic [31:0] e,
			logic [31:0] t);
		logic [31:0] span;
		if (e >= b) begin
			span = e - b;
		end else begin
			span = TIME_WRAP - b + e;
		end
		return span > t;
	endfunction

endpackage

/* sv/pklpc_item_if.sv */
// ----------------------------------------------------------------------------
// pklpc_item_if
// Input channel: one polled key and rail sample with its timestamp.
// ----------------------------------------------------------------------------
interface pklpc_item_if;
	logic        valid;
	logic        ready;
	logic        key_level;
	logic        rail_level;
	logic [31:0] now_time;

	modport source (output valid, key_level, rail_level, now_time, input ready);
	modport sink (input valid, key_level, rail_level, now_time, output ready);
endinterface

/* sv/pklpc_result_if.sv */
// ----------------------------------------------------------------------------
// pklpc_result_if
// Result channel: power-on, shutdown and forced power-off pulses.
// ----------------------------------------------------------------------------
interface pklpc_result_if;
	logic valid;
	logic ready;
	logic power_on_req;
	logic shutdown_req;
	logic force_off;

	modport source (output valid, power_on_req, shutdown_req, force_off, input ready);
	modport sink (input valid, power_on_req, shutdown_req, force_off, output ready);
endinterface

/* sv/pklpc_cfg_if.sv */
// ----------------------------------------------------------------------------
// pklpc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pklpc_cfg_if;
	logic                      valid;
	logic                      ready;
	pklpc_pkg::reg_index_t     index;
	logic [31:0]               data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/power_key_long_press_controller_top.sv */
// ----------------------------------------------------------------------------
// power_key_long_press_controller_top
// Power key long-press controller: per poll decides power-on, shutdown
// request and forced power-off from key level, rail level and timestamp.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register, which loads when the
// stage advances; the state update between them is combinational.
// Throughput: one item per cycle while the result channel is not stalled.
// Reset: arst_n clears all press state and loads release_ticks = 5000 and
// long_press_ticks = 50000; both channels come out of reset empty.
module power_key_long_press_controller_top (
	input  logic                   clk,
	input  logic                   arst_n,
	pklpc_item_if.sink             item,
	pklpc_result_if.source         result,
	pklpc_cfg_if.sink              cfg
);
	import pklpc_pkg::*;

	// configuration registers
	logic [31:0] release_ticks_q;
	logic [31:0] long_press_ticks_q;

	// input register
	logic  valid_s1;
	item_t item_s1;

	// result register
	logic    res_valid_q;
	result_t res_q;

	// press state
	logic        on_pressed_q, on_released_q;
	logic [31:0] on_release_time_q;
	logic        off_pressed_q, off_released_q, off_done_q;
	logic [31:0] off_press_time_q, off_release_time_q;

	// next state and result
	logic        on_pressed_d, on_released_d;
	logic [31:0] on_release_time_d;
	logic        off_pressed_d, off_released_d, off_done_d;
	logic [31:0] off_press_time_d, off_release_time_d;
	result_t     res_d;

	logic advance;
	logic key_high, rail;
	logic [31:0] now;

	// stage advances when the result register is empty or being taken
	assign advance    = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_ticks_q    <= RELEASE_TICKS_RST;
			long_press_ticks_q <= LONG_PRESS_TICKS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_RELEASE_TICKS:    release_ticks_q    <= cfg.data;
				REG_LONG_PRESS_TICKS: long_press_ticks_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.key_level  <= item.key_level;
			item_s1.rail_level <= item.rail_level;
			item_s1.now_time   <= item.now_time;
		end
	end

	assign key_high = item_s1.key_level;
	assign rail     = item_s1.rail_level;
	assign now      = item_s1.now_time;

	// power-on and power-off path decisions for the item in the input register
	always_comb begin
		on_pressed_d       = on_pressed_q;
		on_released_d      = on_released_q;
		on_release_time_d  = on_release_time_q;
		off_pressed_d      = off_pressed_q;
		off_released_d     = off_released_q;
		off_done_d         = off_done_q;
		off_press_time_d   = off_press_time_q;
		off_release_time_d = off_release_time_q;
		res_d              = '0;

		if ((!rail || on_pressed_q) && !off_pressed_q) begin
			// power-on path: press switches on at once, then wait for release
			if (!on_pressed_d && !key_high) begin
				on_pressed_d       = 1'b1;
				res_d.power_on_req = 1'b1;
			end
			if (on_pressed_d && !on_released_d && key_high) begin
				on_released_d     = 1'b1;
				on_release_time_d = now;
			end
			if (on_released_d) begin
				if (interval_exceeds(on_release_time_d, now, release_ticks_q)) begin
					on_pressed_d      = 1'b0;
					on_released_d     = 1'b0;
					on_release_time_d = '0;
				end
				if (!key_high) begin
					on_released_d = 1'b0;
				end
			end
		end else if ((rail || off_pressed_q) && !on_pressed_q) begin
			// power-off path: time the press, then the release
			if (!off_pressed_d && !key_high) begin
				off_pressed_d    = 1'b1;
				off_press_time_d = now;
			end
			if (off_pressed_d && !off_released_d && key_high) begin
				off_released_d     = 1'b1;
				off_release_time_d = now;
			end
			if (off_released_d) begin
				if (interval_exceeds(off_release_time_d, now, release_ticks_q)) begin
					// long press released before force-off: shutdown only
					if (!off_done_d && interval_exceeds(off_press_time_d,
							off_release_time_d, long_press_ticks_q)) begin
						res_d.shutdown_req = 1'b1;
					end
					off_pressed_d      = 1'b0;
					off_press_time_d   = '0;
					off_released_d     = 1'b0;
					off_release_time_d = '0;
					off_done_d         = 1'b0;
				end
				if (!key_high) begin
					off_released_d = 1'b0;
				end
			end
			// held past the long-press time: shutdown and force off
			if (off_pressed_d && !off_done_d &&
					interval_exceeds(off_press_time_d, now, long_press_ticks_q)) begin
				res_d.shutdown_req = 1'b1;
				res_d.force_off    = 1'b1;
				off_done_d         = 1'b1;
			end
		end
	end

	// press state update on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_pressed_q       <= 1'b0;
			on_released_q      <= 1'b0;
			on_release_time_q  <= '0;
			off_pressed_q      <= 1'b0;
			off_released_q     <= 1'b0;
			off_done_q         <= 1'b0;
			off_press_time_q   <= '0;
			off_release_time_q <= '0;
		end else if (valid_s1 && advance) begin
			on_pressed_q       <= on_pressed_d;
			on_released_q      <= on_released_d;
			on_release_time_q  <= on_release_time_d;
			off_pressed_q      <= off_pressed_d;
			off_released_q     <= off_released_d;
			off_done_q         <= off_done_d;
			off_press_time_q   <= off_press_time_d;
			off_release_time_q <= off_release_time_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.power_on_req = res_q.power_on_req;
	assign result.shutdown_req = res_q.shutdown_req;
	assign result.force_off    = res_q.force_off;

	// power-on and power-off paths never hold a press at the same time
	a_paths_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(on_pressed_q && off_pressed_q))
		else $error("power-on and power-off presses both active");

	// a release wait only exists inside a press
	a_on_release_in_press: assert property (@(posedge clk) disable iff (!arst_n)
		on_released_q |-> on_pressed_q)
		else $error("power-on release pending without press");

	// forced off is only remembered while the press lasts
	a_done_in_press: assert property (@(posedge clk) disable iff (!arst_n)
		(off_done_q || off_released_q) |-> off_pressed_q)
		else $error("power-off state set without press");

	// force-off always comes with a shutdown request and never with power-on
	a_force_with_shutdown: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((!res_q.force_off || res_q.shutdown_req) &&
			!(res_q.power_on_req && res_q.shutdown_req)))
		else $error("inconsistent result pulses");

endmodule
